// ===== design/dpw4_pkg.sv =====
// Package for the DPW4 sawtooth oscillator: constants and the saturating
// Q2.62 helper functions used by the oscillator datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package dpw4_pkg;

  localparam int PHASE_BITS_DEF = 32;
  localparam int OUT_BITS_DEF   = 24;

  localparam int FREQ_W = 31;
  localparam int SR_W   = 18;
  localparam int ADDR_W = 3;

  localparam logic [ADDR_W-1:0] ADDR_SAMPLE_RATE = 3'd0;
  localparam logic [SR_W-1:0]   SR_RESET         = 18'd48000;

  localparam logic [FREQ_W-1:0] FADE_LO = 31'(400 << 16);
  localparam logic [FREQ_W-1:0] FADE_HI = 31'(600 << 16);
  localparam logic [30:0]       G_ONE   = 31'h4000_0000;
  localparam logic [63:0]       G_DIV   = 64'd160000;

  // u^2 / 160000 is taken as (u^2 >> 8) / 625, and the division by 625 as a
  // multiply by ceil(2^50 / 625) followed by a shift of 50. This is exact for
  // every numerator below 2^40, which covers the whole crossfade band.
  localparam int          G_PRE_SHIFT   = 8;
  localparam int          G_RECIP_SHIFT = 50;
  localparam logic [63:0] G_RECIP       = 64'd1801439850949;

  localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;

  // Magnitude of a signed 64-bit value, as unsigned.
  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  // Signed value from a magnitude and a sign, saturated to 64 bits.
  function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
    logic signed [63:0] r;
    if (neg) begin
      r = m[63] ? $signed(NEG_LIM) : $signed(64'd0 - m);
    end else begin
      r = m[63] ? $signed(POS_LIM) : $signed(m);
    end
    return r;
  endfunction

  // Q2.62 product from a full magnitude product and the result sign.
  function automatic logic signed [63:0] q62_take(input logic [127:0] p, input logic neg);
    logic [63:0] m;
    m = (p[127:126] != 2'b00) ? NEG_LIM : p[125:62];
    return from_mag(m, neg);
  endfunction

  // a - b, saturated to the signed 64-bit range.
  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) begin
      return d[64] ? $signed(NEG_LIM) : $signed(POS_LIM);
    end
    return d[63:0];
  endfunction

  // Division by 2^k, truncated toward zero.
  function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v,
                                                     input int k);
    logic [63:0] m;
    m = mag(v) >> k;
    return v[63] ? $signed(64'd0 - m) : $signed(m);
  endfunction

endpackage

// ===== design/dpw4_sawtooth_oscillator.sv =====
// Top level of the DPW4 sawtooth oscillator: sequencer, shared multiplier,
// shared divider and the APB-style configuration register.
// Depends on dpw4_pkg.
`timescale 1ns / 1ps

//  Channel  | Ports                                   | Moves
//  ---------+-----------------------------------------+-------------------------
//  input    | in_valid, in_stall, in_freq_hz          | one frequency per tick
//  output   | out_valid, out_stall, out_sample/clipped| one sample per tick
//  config   | psel, penable, pwrite, paddr, pwdata,   | sample_rate_hz at 0x0
//           | prdata, pready                          |
//
// Each transaction runs the whole per-sample recipe, and takes longer when the
// frequency lies in the crossfade band. Its length is set by the shared
// restoring divider, which retires one quotient bit per cycle over 64
// iterations and is called up to five times per sample; the shared 32x32
// multiplier is used for every product, and the crossfade weight costs two
// extra products. in_stall is high for the whole transaction. The finished
// sample sits in an output register, so the next input transaction is taken
// while it still waits on out_stall.
// Reset (synchronous, rst_n low) puts the phase at one half, clears all
// differentiator state and loads a sample rate of 48000 Hz.

module dpw4_sawtooth_oscillator #(
  parameter int PHASE_BITS = dpw4_pkg::PHASE_BITS_DEF,
  parameter int OUT_BITS   = dpw4_pkg::OUT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dpw4_pkg::FREQ_W-1:0]     in_freq_hz,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [OUT_BITS-1:0]      out_sample,
  output logic                            out_clipped,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dpw4_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int OUT_SHIFT = 32 - OUT_BITS;
  localparam logic signed [63:0] OUT_HI = 64'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [63:0] OUT_LO = -OUT_HI - 64'sd1;

  // The sequencer walks the per-sample recipe; MUL and DIV are shared
  // sub-sequences that return to the state held in ret_r.
  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_STEP, ST_SQ, ST_D2M, ST_D2D, ST_QM, ST_E2, ST_E3,
    ST_YM, ST_YD, ST_G, ST_GM, ST_GD, ST_M1, ST_M1R, ST_M2R, ST_OUT
  } state_t;

  state_t state_r, ret_r;

  logic [dpw4_pkg::SR_W-1:0]   sr_cfg_r;
  logic [dpw4_pkg::SR_W-1:0]   sr_r;
  logic [dpw4_pkg::FREQ_W-1:0] f_r;
  logic [PHASE_BITS-1:0]       phase_r;
  logic signed [63:0]          sqp_r, dpw2_r, qd1_r, qd2_r, qd3_r;
  logic signed [63:0]          prev2_r, sq_r, v_r, y4_r, t4_r, mix_r;
  logic [30:0]                 g_r;
  logic [1:0]                  k_r;
  logic                        neg_r;

  // shared multiplier
  logic [63:0]  ma_r, mb_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [2:0]   mcnt_r;
  logic [127:0] prod_r;

  // shared divider
  logic [63:0] r_r, nlo_r, d_r, q_r, lim_r;
  logic [5:0]  dcnt_r;

  // combinational helpers
  logic [63:0]           fz, srz, f192, in_fz, in_srz;
  logic [PHASE_BITS-1:0] ph_new;
  logic signed [63:0]    x_val, sq_val, d1_val, quart_val, e_val, sqm_val;
  logic signed [63:0]    sc_val, t2_val, sum_val, s_val;
  logic [63:0]           q_sat;
  logic [31:0]           pa, pb;
  logic [63:0]           r_sh, r_sub;
  logic                  r_ge;
  logic                  cfg_wr;

  assign pready   = 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign prdata   = (paddr == dpw4_pkg::ADDR_SAMPLE_RATE) ? {14'd0, sr_cfg_r} : 32'd0;
  assign cfg_wr   = psel && penable && pwrite && (paddr == dpw4_pkg::ADDR_SAMPLE_RATE);

  always_comb begin
    in_fz  = {33'd0, (in_freq_hz == '0) ? 31'd1 : in_freq_hz};
    in_srz = {46'd0, (sr_cfg_r == '0) ? 18'd1 : sr_cfg_r};
    fz     = {33'd0, f_r};
    srz    = {46'd0, sr_r};
    f192   = (fz << 7) + (fz << 6);

    // bipolar phase in Q2.62: the offset phase, sign-extended by two bits
    ph_new = phase_r + q_r[PHASE_BITS-1:0];
    x_val  = {{2{~ph_new[PHASE_BITS-1]}}, ph_new[PHASE_BITS-2:0],
              {(63-PHASE_BITS){1'b0}}};

    sq_val    = dpw4_pkg::q62_take(prod_r, 1'b0);
    d1_val    = dpw4_pkg::sub_sat(sq_val, sqp_r);
    sqm_val   = {~sq_r[63], sq_r[62:0]};
    quart_val = dpw4_pkg::q62_take(prod_r, neg_r);
    e_val     = dpw4_pkg::sub_sat(quart_val, qd1_r);

    q_sat  = (q_r > lim_r) ? lim_r : q_r;
    sc_val = dpw4_pkg::from_mag(q_sat, neg_r);

    t2_val  = prev2_r[63] ? $signed(64'd0 - prod_r[63:0]) : $signed(prod_r[63:0]);
    sum_val = t4_r + t2_val;
    s_val   = dpw4_pkg::trunc_shift(mix_r, OUT_SHIFT);

    // one 32x32 partial product per cycle
    pa = mcnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    pb = mcnt_r[0] ? mb_r[63:32] : mb_r[31:0];

    // one restoring division step per cycle
    r_sh  = {r_r[62:0], nlo_r[63]};
    r_ge  = r_r[63] || (r_sh >= d_r);
    r_sub = r_ge ? (r_sh - d_r) : r_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      sr_cfg_r    <= dpw4_pkg::SR_RESET;
      phase_r     <= {1'b1, {(PHASE_BITS-1){1'b0}}};
      sqp_r       <= '0;
      dpw2_r      <= '0;
      qd1_r       <= '0;
      qd2_r       <= '0;
      qd3_r       <= '0;
      out_valid   <= 1'b0;
      mcnt_r      <= '0;
      dcnt_r      <= '0;
      k_r         <= '0;
    end else begin
      if (cfg_wr) begin
        sr_cfg_r <= pwdata[dpw4_pkg::SR_W-1:0];
      end
      // in ST_OUT the output register is reloaded instead
      if (out_valid && !out_stall && (state_r != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            f_r     <= in_fz[30:0];
            sr_r    <= in_srz[17:0];
            prev2_r <= dpw2_r;
            r_r     <= '0;
            nlo_r   <= in_fz << (PHASE_BITS - 16);
            d_r     <= in_srz;
            lim_r   <= '1;
            q_r     <= '0;
            dcnt_r  <= 6'd63;
            ret_r   <= ST_STEP;
            state_r <= ST_DIV;
          end
        end

        ST_DIV: begin
          r_r   <= r_sub;
          nlo_r <= {nlo_r[62:0], 1'b0};
          q_r   <= {q_r[62:0], r_ge};
          if (dcnt_r == '0) begin
            state_r <= ret_r;
          end else begin
            dcnt_r <= dcnt_r - 6'd1;
          end
        end

        ST_MUL: begin
          if (mcnt_r != 3'd4) begin
            pp_r <= 64'(pa) * 64'(pb);
            sh_r <= {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
          end
          if (mcnt_r != 3'd0) begin
            prod_r <= prod_r + ({64'd0, pp_r} << {sh_r, 5'd0});
          end
          if (mcnt_r == 3'd4) begin
            state_r <= ret_r;
          end else begin
            mcnt_r <= mcnt_r + 3'd1;
          end
        end

        ST_STEP: begin
          phase_r <= ph_new;
          ma_r    <= dpw4_pkg::mag(x_val);
          mb_r    <= dpw4_pkg::mag(x_val);
          prod_r  <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_SQ;
          state_r <= ST_MUL;
        end

        ST_SQ: begin
          sq_r    <= sq_val;
          sqp_r   <= sq_val;
          neg_r   <= d1_val[63];
          ma_r    <= dpw4_pkg::mag(d1_val);
          mb_r    <= srz << 14;
          prod_r  <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_D2M;
          state_r <= ST_MUL;
        end

        ST_D2M: begin
          lim_r  <= neg_r ? dpw4_pkg::NEG_LIM : dpw4_pkg::POS_LIM;
          d_r    <= fz;
          r_r    <= prod_r[127:64];
          nlo_r  <= prod_r[63:0];
          dcnt_r <= 6'd63;
          ret_r  <= ST_D2D;
          if (prod_r[127:64] >= fz) begin
            q_r     <= neg_r ? dpw4_pkg::NEG_LIM : dpw4_pkg::POS_LIM;
            state_r <= ST_D2D;
          end else begin
            q_r     <= '0;
            state_r <= ST_DIV;
          end
        end

        ST_D2D: begin
          dpw2_r  <= sc_val;
          neg_r   <= sqm_val[63];
          ma_r    <= dpw4_pkg::mag(sq_r);
          mb_r    <= dpw4_pkg::mag(sqm_val);
          prod_r  <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_QM;
          state_r <= ST_MUL;
        end

        ST_QM: begin
          qd1_r   <= quart_val;
          v_r     <= e_val;
          state_r <= ST_E2;
        end

        ST_E2: begin
          qd2_r   <= v_r;
          v_r     <= dpw4_pkg::sub_sat(v_r, qd2_r);
          state_r <= ST_E3;
        end

        ST_E3: begin
          qd3_r   <= v_r;
          // third difference feeds the first period scaling
          neg_r   <= dpw4_pkg::sub_sat(v_r, qd3_r) < 0;
          ma_r    <= dpw4_pkg::mag(dpw4_pkg::sub_sat(v_r, qd3_r));
          mb_r    <= srz << 16;
          prod_r  <= '0;
          mcnt_r  <= '0;
          k_r     <= '0;
          ret_r   <= ST_YM;
          state_r <= ST_MUL;
        end

        ST_YM: begin
          lim_r  <= neg_r ? dpw4_pkg::NEG_LIM : dpw4_pkg::POS_LIM;
          d_r    <= (k_r == 2'd0) ? f192 : fz;
          r_r    <= prod_r[127:64];
          nlo_r  <= prod_r[63:0];
          dcnt_r <= 6'd63;
          ret_r  <= ST_YD;
          if (prod_r[127:64] >= ((k_r == 2'd0) ? f192 : fz)) begin
            q_r     <= neg_r ? dpw4_pkg::NEG_LIM : dpw4_pkg::POS_LIM;
            state_r <= ST_YD;
          end else begin
            q_r     <= '0;
            state_r <= ST_DIV;
          end
        end

        ST_YD: begin
          if (k_r != 2'd2) begin
            k_r     <= k_r + 2'd1;
            neg_r   <= sc_val[63];
            ma_r    <= dpw4_pkg::mag(sc_val);
            mb_r    <= srz << 16;
            prod_r  <= '0;
            mcnt_r  <= '0;
            ret_r   <= ST_YM;
            state_r <= ST_MUL;
          end else begin
            y4_r    <= sc_val;
            state_r <= ST_G;
          end
        end

        ST_G: begin
          if (f_r > dpw4_pkg::FADE_HI) begin
            g_r     <= dpw4_pkg::G_ONE;
            state_r <= ST_M1;
          end else if (f_r > dpw4_pkg::FADE_LO) begin
            ma_r    <= {33'd0, f_r - dpw4_pkg::FADE_LO};
            mb_r    <= {33'd0, f_r - dpw4_pkg::FADE_LO};
            prod_r  <= '0;
            mcnt_r  <= '0;
            ret_r   <= ST_GM;
            state_r <= ST_MUL;
          end else begin
            g_r     <= '0;
            state_r <= ST_M1;
          end
        end

        ST_GM: begin
          // u^2 / 160000 by a reciprocal product on the shared multiplier
          ma_r    <= prod_r[63:0] >> dpw4_pkg::G_PRE_SHIFT;
          mb_r    <= dpw4_pkg::G_RECIP;
          prod_r  <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_GD;
          state_r <= ST_MUL;
        end

        ST_GD: begin
          g_r     <= prod_r[dpw4_pkg::G_RECIP_SHIFT +: 31];
          state_r <= ST_M1;
        end

        ST_M1: begin
          ma_r    <= {33'd0, g_r};
          mb_r    <= dpw4_pkg::mag(y4_r) >> 31;
          prod_r  <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_M1R;
          state_r <= ST_MUL;
        end

        ST_M1R: begin
          t4_r    <= y4_r[63] ? $signed(64'd0 - prod_r[63:0]) : $signed(prod_r[63:0]);
          ma_r    <= {33'd0, dpw4_pkg::G_ONE - g_r};
          mb_r    <= dpw4_pkg::mag(prev2_r) >> 31;
          prod_r  <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_M2R;
          state_r <= ST_MUL;
        end

        ST_M2R: begin
          mix_r   <= dpw4_pkg::trunc_shift(sum_val, 30);
          state_r <= ST_OUT;
        end

        ST_OUT: begin
          // hold here until the previous sample has been taken
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (s_val > OUT_HI) begin
              out_sample  <= OUT_HI[OUT_BITS-1:0];
              out_clipped <= 1'b1;
            end else if (s_val < OUT_LO) begin
              out_sample  <= OUT_LO[OUT_BITS-1:0];
              out_clipped <= 1'b1;
            end else begin
              out_sample  <= s_val[OUT_BITS-1:0];
              out_clipped <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
